[hw/rtl/pfp_pkg.sv]
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and codes of the four-plane pixel port: request and response
// words, the action codes and the control word of the read-modify-write stage.
// ----------------------------------------------------------------------------
package pfp_pkg;

   // action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   localparam int PLANES     = 4;
   localparam int PLANE_BITS = 8;

   // one request word
   typedef struct packed {
      logic        action;
      logic        use_linear;
      logic [9:0]  x;
      logic [8:0]  y;
      logic [18:0] linear_pos;
      logic [3:0]  color;
      logic        span_last;
   } req_type;

   // one response word
   typedef struct packed {
      logic [3:0] read_color;
      logic       result_last;
   } rsp_type;

   // control of the read-modify-write stage
   typedef struct packed {
      logic       valid;
      logic       action;
      logic [2:0] bit_sel;
      logic [3:0] color;
      logic       last;
   } rmw_ctl_type;

endpackage

[hw/rtl/pfp_ram.sv]
// ----------------------------------------------------------------------------
// pfp_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// A read of the entry written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module pfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pfp_rmw.sv]
// ----------------------------------------------------------------------------
// pfp_rmw
// Read-modify-write stage: takes the plane word read from the store, forwards
// the previous cycle's write over it when the address matches, then either
// updates the pixel bit in all four planes or gathers them into a colour.
// ----------------------------------------------------------------------------
module pfp_rmw
   import pfp_pkg::*;
#(
   parameter int ADDR_W = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rmw_ctl_type                       ctl,
   input  logic [ADDR_W-1:0]                 addr,
   input  logic [PLANES*PLANE_BITS-1:0]      rd_data,
   output logic                              wr_en,
   output logic [ADDR_W-1:0]                 wr_addr,
   output logic [PLANES*PLANE_BITS-1:0]      wr_data,
   output logic                              rsp_valid,
   output rsp_type                           rsp_data
);

   localparam int WORD_W = PLANES * PLANE_BITS;

   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [WORD_W-1:0] fwd_data_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;
   logic [WORD_W-1:0] cur_word;
   logic [WORD_W-1:0] new_word;

   // the store misses the write of the previous cycle on a same-address read
   assign cur_word = (fwd_valid_ff && (fwd_addr_ff == addr)) ? fwd_data_ff : rd_data;

   // update or gather the pixel bit of each plane
   always_comb begin
      new_word    = cur_word;
      rsp_data_in = '0;
      for (int p = 0; p < PLANES; p++) begin
         new_word[{p[1:0], ctl.bit_sel}]  = ctl.color[p];
         rsp_data_in.read_color[p]        = cur_word[{p[1:0], ctl.bit_sel}];
      end
      rsp_data_in.result_last = ctl.last;
   end

   assign wr_en   = ctl.valid && (ctl.action == ACT_WRITE);
   assign wr_addr = addr;
   assign wr_data = new_word;

   // forwarding register and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
         rsp_valid_ff <= ctl.valid && (ctl.action == ACT_READ);
      end
      fwd_addr_ff <= addr;
      fwd_data_ff <= new_word;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/planar_four_plane_pixel_port_top.sv]
// ----------------------------------------------------------------------------
// planar_four_plane_pixel_port_top
// Four-plane 16-colour pixel port: writes or reads one pixel per word.
//
// Usage: a request word is taken on a rising edge with start high and busy
// low. It addresses a pixel by x,y (y * LINE_PIXELS + x) or by linear
// position; the byte address is position / 8 wrapped to PLANE_DEPTH, the
// bit is MSB-first. A write updates that bit in all four plane bytes and
// gives no response. A read gives one response word, rsp_valid high for
// exactly one cycle, once the word has passed the pipeline registers and the response register.
// Throughput: one word per cycle while busy is low. The plane store is one
// 32-bit RAM with registered read data; a read-modify-write on the same
// byte in back-to-back cycles is served by forwarding the last write.
// Reset: the store is swept to zero, one entry per cycle, over all
// PLANE_DEPTH entries; busy stays high during the sweep.
// The receiver cannot stall: each response must be taken in its cycle.
// ----------------------------------------------------------------------------
module planar_four_plane_pixel_port_top
   import pfp_pkg::*;
#(
   parameter int LINE_PIXELS = 640,
   parameter int PLANE_DEPTH = 65536
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int ADDR_W    = $clog2(PLANE_DEPTH);
   localparam int LP_W      = $clog2(LINE_PIXELS + 1);
   localparam int POS_W     = (10 + LP_W > 20) ? 10 + LP_W : 20;
   localparam int BA_W      = POS_W - 3;
   localparam int MOD_STEPS = BA_W - ADDR_W + 1;
   localparam int WORD_W    = PLANES * PLANE_BITS;
   localparam logic [BA_W:0] DEPTH_EXT = (BA_W + 1)'(PLANE_DEPTH);

   logic              clr_active_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic              s2_valid_ff;
   logic [BA_W-1:0]   s2_baddr_ff;
   logic [2:0]        s2_pix_ff;
   req_type           s2_req_ff;
   rmw_ctl_type       s3_ctl_ff;
   logic [ADDR_W-1:0] s3_addr_ff;
   logic [POS_W-1:0]  s1_pos;
   logic [BA_W:0]     s2_rem;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              pipe_wr_en;
   logic [ADDR_W-1:0] pipe_wr_addr;
   logic [WORD_W-1:0] pipe_wr_data;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              accept;

   assign busy   = clr_active_ff;
   assign accept = start && !busy;

   // stage 1: pixel position
   assign s1_pos = s1_req_ff.use_linear ? POS_W'(s1_req_ff.linear_pos)
      : POS_W'(s1_req_ff.y) * POS_W'(LINE_PIXELS) + POS_W'(s1_req_ff.x);

   // stage 2: byte address wrapped to the store depth
   always_comb begin
      s2_rem = {1'b0, s2_baddr_ff};
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (s2_rem >= (DEPTH_EXT << k)) begin
            s2_rem = s2_rem - (DEPTH_EXT << k);
         end
      end
   end

   assign rd_addr = s2_rem[ADDR_W-1:0];

   // pipeline registers and the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_ctl_ff     <= '0;
      end else begin
         if (clr_active_ff) begin
            if (clr_addr_ff == ADDR_W'(PLANE_DEPTH - 1)) begin
               clr_active_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         s1_valid_ff       <= accept;
         s2_valid_ff       <= s1_valid_ff;
         s3_ctl_ff.valid   <= s2_valid_ff;
         s3_ctl_ff.action  <= s2_req_ff.action;
         s3_ctl_ff.bit_sel <= 3'd7 - s2_pix_ff;
         s3_ctl_ff.color   <= s2_req_ff.color;
         s3_ctl_ff.last    <= s2_req_ff.span_last;
      end
      s1_req_ff   <= req_data;
      s2_req_ff   <= s1_req_ff;
      s2_baddr_ff <= s1_pos[POS_W-1:3];
      s2_pix_ff   <= s1_pos[2:0];
      s3_addr_ff  <= rd_addr;
   end

   // store write port shared by the sweep and the pipeline
   assign ram_wr_en   = clr_active_ff || pipe_wr_en;
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : pipe_wr_addr;
   assign ram_wr_data = clr_active_ff ? '0 : pipe_wr_data;

   pfp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PLANE_DEPTH)
   ) u_plane_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfp_rmw #(
      .ADDR_W (ADDR_W)
   ) u_rmw (
      .clock     (clock),
      .reset     (reset),
      .ctl       (s3_ctl_ff),
      .addr      (s3_addr_ff),
      .rd_data   (rd_data),
      .wr_en     (pipe_wr_en),
      .wr_addr   (pipe_wr_addr),
      .wr_data   (pipe_wr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // no word in flight while the store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s2_valid_ff && !s3_ctl_ff.valid)
      else $error("word in flight during clearing sweep");

   // the sweep owns the write port
   assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !pipe_wr_en)
      else $error("pipeline write during clearing sweep");

   // a response follows an accepted read request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(reset, 4) |->
         $past(accept && (req_data.action == ACT_READ), 4))
      else $error("response without matching read request");

endmodule
